// File: hdl/stepper_step_sequencer_macros.svh
// assertion macros for the stepper step sequencer
`ifndef STEPPER_STEP_SEQUENCER_MACROS_SVH
`define STEPPER_STEP_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked only out of reset
`define SSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stepper sequencer check failed");

// next-cycle implication, checked only out of reset
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stepper sequencer check failed");

`else

`define SSS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/sss_pkg.sv
// shared widths, register codes and constants of the stepper step sequencer
`timescale 1ns / 1ps

package sss_pkg;

    localparam int DELAY_W   = 24;
    localparam int REV_W     = 13;
    localparam int POS_W     = 12;
    localparam int BUDGET_W  = 27;
    localparam int ROT_W     = 16;
    localparam int MAG_W     = ROT_W + 1;
    localparam int PROD_W    = MAG_W + REV_W;
    localparam int PHASE_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = DELAY_W;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_SHAFT = 2'd2;

    localparam logic [DELAY_W-1:0]  DELAY_RESET   = 24'd2000;
    localparam logic [REV_W-1:0]    REV_RESET     = 13'd2048;
    localparam logic [REV_W-1:0]    SHAFT_RESET   = 13'd2048;
    localparam logic [BUDGET_W-1:0] BUDGET_MAX    = {BUDGET_W{1'b1}};
    localparam logic [DELAY_W-1:0]  ELAPSED_MAX   = {DELAY_W{1'b1}};
    localparam logic [REV_W-1:0]    POS_LIMIT     = 13'd4096;

endpackage

// File: hdl/sss_req_if.sv
// request and result channel interfaces of the stepper step sequencer
`timescale 1ns / 1ps

interface sss_req_if
    import sss_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    func;
    logic signed [ROT_W-1:0] rotations;

    modport source (output valid, output func, output rotations, input ready);
    modport sink (input valid, input func, input rotations, output ready);
endinterface

interface sss_rsp_if
    import sss_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PHASE_W-1:0]  phase;
    logic                coils_on;
    logic                stepped;
    logic [BUDGET_W-1:0] steps_remaining;

    modport source (output valid, output phase, output coils_on, output stepped,
                    output steps_remaining, input ready);
    modport sink (input valid, input phase, input coils_on, input stepped,
                  input steps_remaining, output ready);
endinterface

// File: hdl/stepper_step_sequencer.sv
// the output register holds a transaction's result from the cycle after it is taken
// throughput: one transaction per cycle, the output register takes a new result
//   whenever it is empty or its result leaves in the same cycle
// all motor state updates in the single accept cycle; budget product is one 17x13 multiply
// reset: position, budget, elapsed count, direction and coils clear; registers load defaults
`timescale 1ns / 1ps

`include "stepper_step_sequencer_macros.svh"

module stepper_step_sequencer
    import sss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sss_req_if.sink               req,
    sss_rsp_if.source             rsp,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [DELAY_W-1:0]  delay_reg;
    logic [REV_W-1:0]    rev_reg;
    logic [REV_W-1:0]    shaft_reg;

    logic [BUDGET_W-1:0] steps_left_reg, steps_left_next;
    logic                dir_fwd_reg, dir_fwd_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [DELAY_W-1:0]  elapsed_reg, elapsed_next;
    logic                coils_reg, coils_next;

    logic                out_valid_reg;
    logic                stepped_reg;
    logic                stepped_next;

    logic                accept;
    logic [DELAY_W-1:0]  elapsed_inc;
    logic [REV_W-1:0]    modulus;
    logic [POS_W-1:0]    pos_fwd;
    logic [POS_W-1:0]    pos_back;
    logic [ROT_W-1:0]    rot_bits;
    logic [MAG_W-1:0]    magnitude;
    logic [PROD_W-1:0]   product;
    logic [BUDGET_W-1:0] budget;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
            rev_reg   <= REV_RESET;
            shaft_reg <= SHAFT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_STEP_DELAY:      delay_reg <= cfg_data;
                REG_STEPS_PER_REV:   rev_reg   <= cfg_data[REV_W-1:0];
                REG_STEPS_PER_SHAFT: shaft_reg <= cfg_data[REV_W-1:0];
                default:             ;
            endcase
        end
    end

    // saturating tick count and position wrap
    assign elapsed_inc = (elapsed_reg != ELAPSED_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign modulus     = (rev_reg == '0 || rev_reg > POS_LIMIT) ? POS_LIMIT : rev_reg;
    assign pos_fwd     = ({1'b0, pos_reg} + 1'b1 >= modulus) ? '0 : pos_reg + 1'b1;
    assign pos_back    = (pos_reg == '0 || {1'b0, pos_reg} >= modulus)
                         ? POS_W'(modulus - 1'b1) : pos_reg - 1'b1;

    // step budget for a start transaction
    assign rot_bits  = $unsigned(req.rotations);
    assign magnitude = rot_bits[ROT_W-1] ? (MAG_W'(1) << ROT_W) - {1'b0, rot_bits}
                                         : {1'b0, rot_bits};
    assign product   = PROD_W'(magnitude) * PROD_W'(shaft_reg);
    assign budget    = (product > PROD_W'(BUDGET_MAX)) ? BUDGET_MAX
                                                       : product[BUDGET_W-1:0];

    always_comb
    begin
        steps_left_next = steps_left_reg;
        dir_fwd_next    = dir_fwd_reg;
        pos_next        = pos_reg;
        elapsed_next    = elapsed_reg;
        coils_next      = coils_reg;
        stepped_next    = 1'b0;
        if (req.func)
        begin
            steps_left_next = budget;
            if (rot_bits[ROT_W-1])
                dir_fwd_next = 1'b0;
            else if (rot_bits != '0)
                dir_fwd_next = 1'b1;
        end
        else
        begin
            elapsed_next = elapsed_inc;
            if (steps_left_reg == '0)
                coils_next = 1'b0;
            else if (elapsed_inc >= delay_reg)
            begin
                elapsed_next    = '0;
                pos_next        = dir_fwd_reg ? pos_fwd : pos_back;
                steps_left_next = steps_left_reg - 1'b1;
                coils_next      = 1'b1;
                stepped_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_left_reg <= '0;
            dir_fwd_reg    <= 1'b0;
            pos_reg        <= '0;
            elapsed_reg    <= '0;
            coils_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                steps_left_reg <= steps_left_next;
                dir_fwd_reg    <= dir_fwd_next;
                pos_reg        <= pos_next;
                elapsed_reg    <= elapsed_next;
                coils_reg      <= coils_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded with the transaction's state update
    always_ff @(posedge clk)
    begin
        if (accept)
            stepped_reg <= stepped_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.phase           = pos_reg[PHASE_W-1:0];
    assign rsp.coils_on        = coils_reg;
    assign rsp.stepped         = stepped_reg;
    assign rsp.steps_remaining = steps_left_reg;

    `SSS_ASSERT_NOW(a_step_drives_coils, clk, rst_n, out_valid_reg && stepped_reg, coils_reg)
    `SSS_ASSERT_NEXT(a_step_counts_down, clk, rst_n, accept && stepped_next,
                     steps_left_reg == $past(steps_left_reg) - 1'b1 && elapsed_reg == '0)
    `SSS_ASSERT_NEXT(a_idle_tick_coils_off, clk, rst_n,
                     accept && !req.func && steps_left_reg == '0, !coils_reg && !stepped_reg)
    `SSS_ASSERT_NEXT(a_stall_holds_state, clk, rst_n, !accept,
                     $stable(steps_left_reg) && $stable(pos_reg) && $stable(elapsed_reg))

endmodule

// File: verif/tb_stepper_step_sequencer.sv
// self-checking testbench for the stepper step sequencer: directed table, then random phases
`timescale 1ns / 1ps

module tb_stepper_step_sequencer;
    import sss_pkg::*;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;
    localparam int   PHASES      = 12;
    localparam int   PHASE_ITEMS = 120;

    typedef struct packed {
        logic [PHASE_W-1:0]  phase;
        logic                coils_on;
        logic                stepped;
        logic [BUDGET_W-1:0] steps_remaining;
    } motor_out_t;

    typedef struct {
        logic                    is_cfg;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic                    func;
        logic signed [ROT_W-1:0] rot;
        logic                    typed;
        motor_out_t              want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sss_req_if req ();
    sss_rsp_if rsp ();

    stepper_step_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // motor model state and its copy of the registers
    logic [DELAY_W-1:0]  delay_cfg;
    logic [REV_W-1:0]    rev_cfg;
    logic [REV_W-1:0]    shaft_cfg;
    logic [BUDGET_W-1:0] budget;
    logic                fwd;
    logic [POS_W-1:0]    position;
    logic [DELAY_W-1:0]  elapsed;
    logic                energized;

    motor_out_t due_outputs [$];
    plan_row_t  plan [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int fail_count;
    int items_sent;
    int starts_sent;
    int outputs_checked;
    int steps_seen;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic motor_out_t advance_motor(input logic func,
                                                 input logic signed [ROT_W-1:0] rot);
        motor_out_t        r;
        logic [MAG_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        logic [REV_W-1:0]  modulus;
        r.stepped = 1'b0;
        if (func == FUNC_START)
        begin
            if (rot[ROT_W-1])
            begin
                mag = 17'h10000 - {1'b0, rot};
                fwd = 1'b0;
            end
            else
            begin
                mag = {1'b0, rot};
                if (rot != 0)
                    fwd = 1'b1;
            end
            prod = PROD_W'(mag) * PROD_W'(shaft_cfg);
            budget = (prod > PROD_W'(BUDGET_MAX)) ? BUDGET_MAX : prod[BUDGET_W-1:0];
        end
        else
        begin
            if (elapsed != ELAPSED_MAX)
                elapsed = elapsed + 1'b1;
            if (budget == 0)
                energized = 1'b0;
            else if (elapsed >= delay_cfg)
            begin
                elapsed = '0;
                modulus = (rev_cfg == 0 || rev_cfg > POS_LIMIT) ? POS_LIMIT : rev_cfg;
                if (fwd)
                    position = ({1'b0, position} + 1'b1 >= modulus) ? '0 : position + 1'b1;
                else if (position == 0 || {1'b0, position} >= modulus)
                    position = POS_W'(modulus - 13'd1);
                else
                    position = position - 1'b1;
                budget = budget - 1'b1;
                energized = 1'b1;
                r.stepped = 1'b1;
            end
        end
        r.phase = position[PHASE_W-1:0];
        r.coils_on = energized;
        r.steps_remaining = budget;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic plan_row_t item_row(input logic func, input int rot);
        plan_row_t r;
        r = '{default: '0};
        r.func = func;
        r.rot = ROT_W'(rot);
        return r;
    endfunction

    function automatic plan_row_t typed_row(input logic func, input int rot,
                                            input logic [BUDGET_W-1:0] remaining);
        plan_row_t r;
        r = item_row(func, rot);
        r.typed = 1'b1;
        // every typed row sits at phase 0 with the coils off and no step
        r.want = '{phase: '0, coils_on: 1'b0, stepped: 1'b0, steps_remaining: remaining};
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_item(input logic func, input logic signed [ROT_W-1:0] rot,
                             input logic typed, input motor_out_t want);
        motor_out_t pred;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.func <= func;
        req.rotations <= rot;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pred = advance_motor(func, rot);
        due_outputs.push_back(typed ? want : pred);
        items_sent++;
        if (func == FUNC_START)
            starts_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (due_outputs.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_STEP_DELAY:      delay_cfg = data[DELAY_W-1:0];
            REG_STEPS_PER_REV:   rev_cfg = data[REV_W-1:0];
            REG_STEPS_PER_SHAFT: shaft_cfg = data[REV_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // receiver stalls
    always @(negedge clk)
        rsp.ready <= ($urandom_range(99) >= rx_idle_pct);

    // result checker
    always @(posedge clk)
    begin
        motor_out_t want;
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (due_outputs.size() == 0)
            begin
                $display("%0t ns: unexpected transaction, expected none, actual phase=%0d",
                         $time, rsp.phase);
                fail_count++;
            end
            else
            begin
                want = due_outputs.pop_front();
                check_field("phase", 32'(want.phase), 32'(rsp.phase));
                check_field("coils_on", 32'(want.coils_on), 32'(rsp.coils_on));
                check_field("stepped", 32'(want.stepped), 32'(rsp.stepped));
                check_field("steps_remaining", 32'(want.steps_remaining),
                            32'(rsp.steps_remaining));
                outputs_checked++;
                if (rsp.stepped === 1'b1)
                    steps_seen++;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("** stepper_step_sequencer: FAILED **");
        $finish;
    end

    initial
    begin
        logic [CFG_DATA_W-1:0]   val;
        logic signed [ROT_W-1:0] rot;
        int                      sel;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.func = FUNC_TICK;
        req.rotations = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_STEP_DELAY;
        cfg_data = '0;
        tx_idle_pct = 38;
        rx_idle_pct = 77;
        fail_count = 0;
        items_sent = 0;
        starts_sent = 0;
        outputs_checked = 0;
        steps_seen = 0;
        delay_cfg = DELAY_RESET;
        rev_cfg = REV_RESET;
        shaft_cfg = SHAFT_RESET;
        budget = '0;
        fwd = 1'b0;
        position = '0;
        elapsed = '0;
        energized = 1'b0;

        // idle tick, zero rotations, largest budgets at default shaft steps
        plan.push_back(typed_row(FUNC_TICK, 0, 27'd0));
        plan.push_back(typed_row(FUNC_START, 0, 27'd0));
        plan.push_back(typed_row(FUNC_START, 32767, 27'd67106816));
        plan.push_back(typed_row(FUNC_START, -32768, 27'd67108864));
        // zero delay: first backward step wraps from position zero
        plan.push_back(cfg_row(REG_STEP_DELAY, 24'd0));
        plan.push_back(item_row(FUNC_TICK, 0));
        plan.push_back(cfg_row(REG_STEPS_PER_SHAFT, 24'd1));
        plan.push_back(item_row(FUNC_START, 1));
        plan.push_back(item_row(FUNC_TICK, 0));
        plan.push_back(item_row(FUNC_TICK, 0));
        // budget saturation and zero shaft steps
        plan.push_back(cfg_row(REG_STEPS_PER_SHAFT, 24'd4096));
        plan.push_back(typed_row(FUNC_START, 32767, 27'd134213632));
        plan.push_back(typed_row(FUNC_START, -32768, BUDGET_MAX));
        plan.push_back(cfg_row(REG_STEPS_PER_SHAFT, 24'd8191));
        plan.push_back(typed_row(FUNC_START, 32767, BUDGET_MAX));
        plan.push_back(cfg_row(REG_STEPS_PER_SHAFT, 24'd0));
        plan.push_back(typed_row(FUNC_START, -5, 27'd0));
        // position left beyond a lowered modulus
        plan.push_back(cfg_row(REG_STEPS_PER_SHAFT, 24'd1));
        plan.push_back(cfg_row(REG_STEPS_PER_REV, 24'd4096));
        plan.push_back(item_row(FUNC_START, -3));
        plan.push_back(item_row(FUNC_TICK, 0));
        plan.push_back(cfg_row(REG_STEPS_PER_REV, 24'd4));
        plan.push_back(item_row(FUNC_TICK, 0));
        plan.push_back(item_row(FUNC_START, 2));
        plan.push_back(item_row(FUNC_TICK, 0));
        // out-of-range modulus acts as the full revolution, then a modulus of one
        plan.push_back(cfg_row(REG_STEPS_PER_REV, 24'd8191));
        plan.push_back(item_row(FUNC_START, -1));
        plan.push_back(item_row(FUNC_TICK, 0));
        plan.push_back(cfg_row(REG_STEPS_PER_REV, 24'd1));
        plan.push_back(item_row(FUNC_START, 1));
        plan.push_back(item_row(FUNC_TICK, 0));
        // waiting ticks keep the coils as they were
        plan.push_back(cfg_row(REG_STEP_DELAY, 24'd2));
        plan.push_back(cfg_row(REG_STEPS_PER_REV, 24'd2048));
        plan.push_back(item_row(FUNC_START, 1));
        plan.push_back(item_row(FUNC_TICK, 0));
        plan.push_back(item_row(FUNC_TICK, 0));
        plan.push_back(cfg_row(REG_STEP_DELAY, 24'hFFFFFF));
        plan.push_back(item_row(FUNC_START, 1));
        plan.push_back(item_row(FUNC_TICK, 0));

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                req.valid <= 1'b0;
                wait_drained();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                send_item(plan[i].func, plan[i].rot, plan[i].typed, plan[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < PHASES / 3)
            begin
                tx_idle_pct = 38;
                rx_idle_pct = 77;
            end
            else if (ph < 2 * PHASES / 3)
            begin
                tx_idle_pct = 77;
                rx_idle_pct = 38;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            req.valid <= 1'b0;
            wait_drained();

            // short delays dominate so that steps happen often
            sel = $urandom_range(9);
            if (sel <= 5)
                val = CFG_DATA_W'($urandom_range(3));
            else if (sel <= 7)
                val = CFG_DATA_W'($urandom_range(40, 4));
            else if (sel == 8)
                val = '0;
            else
                val = CFG_DATA_W'($urandom);
            write_reg(REG_STEP_DELAY, val);

            sel = $urandom_range(9);
            case (sel)
                0, 1, 2, 3: val = CFG_DATA_W'($urandom_range(8, 1));
                4, 5:       val = CFG_DATA_W'($urandom_range(4096, 1));
                6:          val = 24'd4096;
                7:          val = '0;
                8:          val = CFG_DATA_W'($urandom_range(8191, 4097));
                default:    val = 24'd2048;
            endcase
            write_reg(REG_STEPS_PER_REV, val);

            sel = $urandom_range(9);
            case (sel)
                0, 1, 2, 3, 4, 5: val = CFG_DATA_W'($urandom_range(3));
                6, 7:             val = CFG_DATA_W'($urandom_range(64, 4));
                8:                val = CFG_DATA_W'($urandom_range(8191, 1));
                default:          val = 24'd4096;
            endcase
            write_reg(REG_STEPS_PER_SHAFT, val);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(11) == 0)
                begin
                    if ($urandom_range(9) < 7)
                        rot = ROT_W'($signed($urandom_range(8)) - 4);
                    else
                        rot = ROT_W'($urandom);
                    send_item(FUNC_START, rot, 1'b0, '0);
                end
                else
                    send_item(FUNC_TICK, ROT_W'($urandom), 1'b0, '0);
            end
        end

        req.valid <= 1'b0;
        wait_drained();
        repeat (10) @(negedge clk);

        $display("%0d transactions sent (%0d rotation starts), %0d results checked,",
                 items_sent, starts_sent, outputs_checked);
        $display("%0d motor steps observed across %0d register settings", steps_seen, PHASES);
        if (fail_count == 0)
            $display("** stepper_step_sequencer: PASSED **");
        else
            $display("** stepper_step_sequencer: FAILED **");
        $finish;
    end

endmodule
